// File: hw/rtl/starfield_point_project_macros.svh
// Assertion macros used by the port-level checker file of the star projector.
`ifndef STARFIELD_POINT_PROJECT_MACROS_SVH
`define STARFIELD_POINT_PROJECT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Types and constants shared by the star projector modules.
// ----------------------------------------------------------------------------
package sfp_pkg;

    // Configuration register indexes.
    localparam logic REG_FOCAL = 1'b0;
    localparam logic REG_SPEED = 1'b1;

    localparam logic [11:0] FOCAL_RESET = 12'd400;
    localparam logic [19:0] SPEED_RESET = 20'd16777;

    localparam logic [16:0] DEPTH_ONE = 17'd65536;

    // Brightness numerator 51 * 2^32 and the z^2 bound at or below which the brightness saturates to 255.
    localparam logic [37:0] GRAY_NUM    = 38'd51 << 32;
    localparam logic [33:0] GRAY_SAT_ZZ = 34'd51 << 24;

    // Divider dividend and divisor widths.
    localparam int PIX_NW  = 32;
    localparam int PIX_DW  = 17;
    localparam int GRAY_NW = 38;
    localparam int GRAY_DW = 34;
    localparam int GRAY_QW = 8;

    // Register settings seen by the front end.
    typedef struct packed {
        logic [11:0] focal;
        logic [19:0] speed;
    } cfg_t;

    // One classified star waiting in the queue for the divider pipeline.
    typedef struct packed {
        logic [PIX_NW-1:0]  mag_x;
        logic [PIX_NW-1:0]  mag_y;
        logic [16:0]        z;
        logic [GRAY_DW-1:0] zz;
        logic               vis;
        logic               gray_sat;
        logic [16:0]        next_depth;
    } job_t;

endpackage

// File: hw/rtl/sfp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sfp_div #(
    parameter int NW  = 32,
    parameter int DW  = 17,
    parameter int QW  = 12,
    parameter int LAT = 12
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int CW = NW + DW + QW;

    logic [NW-1:0] rem_in  [LAT];
    logic [DW-1:0] den_in  [LAT];
    logic [QW-1:0] quo_in  [LAT];
    logic [NW-1:0] rem_reg [LAT];
    logic [DW-1:0] den_reg [LAT];
    logic [QW-1:0] quo_reg [LAT];

    assign rem_in[0] = num;
    assign den_in[0] = den;
    assign quo_in[0] = '0;

    for (genvar s = 0; s < LAT; s++) begin : g_stage
        if (s > 0) begin : g_link
            assign rem_in[s] = rem_reg[s-1];
            assign den_in[s] = den_reg[s-1];
            assign quo_in[s] = quo_reg[s-1];
        end

        if (s < QW) begin : g_bit
            localparam int B = QW - 1 - s;
            logic [CW-1:0] shifted;
            logic [CW-1:0] diff;
            logic          ge;

            // Trial subtraction of the shifted divisor.
            assign shifted = CW'(den_in[s]) << B;
            assign ge      = CW'(rem_in[s]) >= shifted;
            assign diff    = CW'(rem_in[s]) - shifted;

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= ge ? diff[NW-1:0] : rem_in[s];
                den_reg[s] <= den_in[s];
                quo_reg[s] <= quo_in[s] | (ge ? (QW'(1) << B) : '0);
            end
        end else begin : g_pass
            // Balancing stage: keeps all dividers at the same latency.
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_in[s];
                den_reg[s] <= den_in[s];
                quo_reg[s] <= quo_in[s];
            end
        end
    end

    assign quo = quo_reg[LAT-1];

endmodule

// File: hw/rtl/sfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_front
// Accepts stars, forms the projection dividends and classifies each star.
// ----------------------------------------------------------------------------
module sfp_front
    import sfp_pkg::*;
#(
    parameter int SCREEN_W = 800,
    parameter int SCREEN_H = 800
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  cfg_t         cfg,
    input  logic [15:0]  star_x,
    input  logic [15:0]  star_y,
    input  logic [16:0]  star_depth,
    input  logic [9:0]   elapsed_ms,
    output logic         push,
    output job_t         job
);

    localparam logic [11:0] CEN_W = 12'(SCREEN_W / 2);
    localparam logic [11:0] CEN_H = 12'(SCREEN_H / 2);
    localparam logic [12:0] LIM_W = 13'(SCREEN_W);
    localparam logic [12:0] LIM_H = 13'(SCREEN_H);

    logic               a_valid_reg;
    logic signed [28:0] fx_reg, fy_reg;
    logic [28:0]        cz_w_reg, cz_h_reg;
    logic [29:0]        lz_w_reg, lz_h_reg;
    logic [33:0]        zz_reg;
    logic [29:0]        msp_reg;
    logic [16:0]        z_reg;

    // First stage: all products of the accepted star.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            fx_reg   <= 29'($signed({1'b0, cfg.focal})) * 29'($signed(star_x));
            fy_reg   <= 29'($signed({1'b0, cfg.focal})) * 29'($signed(star_y));
            cz_w_reg <= 29'(CEN_W) * 29'(star_depth);
            cz_h_reg <= 29'(CEN_H) * 29'(star_depth);
            lz_w_reg <= 30'(LIM_W) * 30'(star_depth);
            lz_h_reg <= 30'(LIM_H) * 30'(star_depth);
            zz_reg   <= 34'(star_depth) * 34'(star_depth);
            msp_reg  <= 30'(elapsed_ms) * 30'(cfg.speed);
            z_reg    <= star_depth;
        end
    end

    logic signed [32:0] num_x, num_y;
    logic [32:0]        abs_x, abs_y;
    logic               ok_x, ok_y;
    logic [21:0]        step_raw;
    logic [16:0]        step;
    logic signed [18:0] d_diff, d_wrap;

    // Second stage: dividends, screen range test and depth update.
    always_comb
    begin
        num_x = {{2{fx_reg[28]}}, fx_reg, 2'b00} + $signed({4'b0000, cz_w_reg});
        num_y = {{2{fy_reg[28]}}, fy_reg, 2'b00} + $signed({4'b0000, cz_h_reg});
        abs_x = num_x[32] ? 33'(-num_x) : 33'(num_x);
        abs_y = num_y[32] ? 33'(-num_y) : 33'(num_y);
        // Negative dividends truncate to column zero only below one divisor.
        ok_x  = num_x[32] ? (abs_x < 33'(z_reg)) : (abs_x < 33'(lz_w_reg));
        ok_y  = num_y[32] ? (abs_y < 33'(z_reg)) : (abs_y < 33'(lz_h_reg));

        step_raw = msp_reg[29:8];
        step     = (step_raw > 22'(DEPTH_ONE)) ? DEPTH_ONE : step_raw[16:0];
        d_diff   = $signed({2'b00, z_reg}) - $signed({2'b00, step});
        if (d_diff <= 0) begin
            d_wrap = d_diff + $signed({2'b00, DEPTH_ONE});
        end else if (d_diff > $signed({2'b00, DEPTH_ONE})) begin
            d_wrap = d_diff - $signed({2'b00, DEPTH_ONE});
        end else begin
            d_wrap = d_diff;
        end

        job.mag_x      = abs_x[31:0];
        job.mag_y      = abs_y[31:0];
        job.z          = z_reg;
        job.zz         = zz_reg;
        job.vis        = ok_x && ok_y && (z_reg != '0);
        job.gray_sat   = zz_reg <= GRAY_SAT_ZZ;
        job.next_depth = d_wrap[16:0];
    end

    assign push = a_valid_reg;

endmodule

// File: hw/rtl/sfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_back
// Job queue and divider pipelines that finish pixel and brightness values.
// ----------------------------------------------------------------------------
module sfp_back
    import sfp_pkg::*;
#(
    parameter int PQW = 10,
    parameter int LAT = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  job_t        job,
    output logic        full,
    output logic        done,
    output logic [9:0]  pixel_col,
    output logic [9:0]  pixel_row,
    output logic        visible,
    output logic [7:0]  gray_level,
    output logic [16:0] next_depth
);

    // Two-entry queue between the front end and the dividers.
    job_t       q_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;
    job_t       head;

    assign pop  = count_reg != 2'd0;
    assign full = count_reg == 2'd2;
    assign head = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= job;
        end
    end

    // Dividers: columns, rows and brightness.
    logic [PQW-1:0]     qx, qy;
    logic [GRAY_QW-1:0] qg;

    sfp_div #(.NW(PIX_NW), .DW(PIX_DW), .QW(PQW), .LAT(LAT)) u_div_x (
        .clk (clk),
        .num (head.mag_x),
        .den (head.z),
        .quo (qx)
    );

    sfp_div #(.NW(PIX_NW), .DW(PIX_DW), .QW(PQW), .LAT(LAT)) u_div_y (
        .clk (clk),
        .num (head.mag_y),
        .den (head.z),
        .quo (qy)
    );

    sfp_div #(.NW(GRAY_NW), .DW(GRAY_DW), .QW(GRAY_QW), .LAT(LAT)) u_div_g (
        .clk (clk),
        .num (GRAY_NUM),
        .den (head.zz),
        .quo (qg)
    );

    // Side information travels alongside the divider stages.
    logic        sv_reg  [LAT];
    logic        vis_reg [LAT];
    logic        sat_reg [LAT];
    logic [16:0] nd_reg  [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                sv_reg[i] <= 1'b0;
            end
        end else begin
            sv_reg[0] <= pop;
            for (int i = 1; i < LAT; i++) begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vis_reg[0] <= head.vis;
        sat_reg[0] <= head.gray_sat;
        nd_reg[0]  <= head.next_depth;
        for (int i = 1; i < LAT; i++) begin
            vis_reg[i] <= vis_reg[i-1];
            sat_reg[i] <= sat_reg[i-1];
            nd_reg[i]  <= nd_reg[i-1];
        end
    end

    // Result register.
    logic [PQW+9:0] colx, rowx;
    logic           done_reg, vis_out_reg;
    logic [9:0]     col_reg, row_reg;
    logic [7:0]     gray_reg;
    logic [16:0]    nd_out_reg;

    assign colx = {10'd0, qx};
    assign rowx = {10'd0, qy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= sv_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        vis_out_reg <= vis_reg[LAT-1];
        col_reg     <= vis_reg[LAT-1] ? colx[9:0] : 10'd0;
        row_reg     <= vis_reg[LAT-1] ? rowx[9:0] : 10'd0;
        gray_reg    <= sat_reg[LAT-1] ? 8'd255 : qg;
        nd_out_reg  <= nd_reg[LAT-1];
    end

    assign done       = done_reg;
    assign pixel_col  = col_reg;
    assign pixel_row  = row_reg;
    assign visible    = vis_out_reg;
    assign gray_level = gray_reg;
    assign next_depth = nd_out_reg;

endmodule

// File: hw/rtl/starfield_point_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// starfield_point_project
// Perspective projection, brightness and depth update of one star per clock.
// ----------------------------------------------------------------------------
// Usage:
// A star is taken at a rising edge with start high and busy low. Its result
// leaves on pixel_col, pixel_row, visible, gray_level and next_depth for one
// cycle, marked by done; the receiver cannot stall and none is needed.
// Registers are written through wr_en, wr_index and wr_data while the block
// is idle: index 0 holds the focal length, index 1 the depth speed.
// Throughput is one star per clock. The result passes the front stage, the
// queue and the bit-per-stage dividers that form the column, the row and the
// brightness, and leaves through the result register.
// A front stage forms products and range tests, a two-entry queue hands the
// job to the divider pipelines; the queue drains one job per clock, so it
// never fills and busy stays low.
// Reset clears all valid flags and restores the register defaults; results
// in flight are dropped.
// ----------------------------------------------------------------------------
module starfield_point_project
    import sfp_pkg::*;
#(
    parameter int SCREEN_W = 800,
    parameter int SCREEN_H = 800
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [19:0]        wr_data,
    input  logic signed [15:0] star_x,
    input  logic signed [15:0] star_y,
    input  logic [16:0]        star_depth,
    input  logic [9:0]         elapsed_ms,
    output logic               done,
    output logic [9:0]         pixel_col,
    output logic [9:0]         pixel_row,
    output logic               visible,
    output logic [7:0]         gray_level,
    output logic [16:0]        next_depth
);

    localparam int QW_W = $clog2(SCREEN_W);
    localparam int QW_H = $clog2(SCREEN_H);
    localparam int PQW  = (QW_W > QW_H) ? QW_W : QW_H;
    localparam int LAT  = (PQW > GRAY_QW) ? PQW : GRAY_QW;

    // Configuration registers.
    logic [11:0] focal_reg;
    logic [19:0] speed_reg;
    cfg_t        cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            focal_reg <= FOCAL_RESET;
            speed_reg <= SPEED_RESET;
        end else if (wr_en) begin
            case (wr_index)
                REG_FOCAL: focal_reg <= wr_data[11:0];
                REG_SPEED: speed_reg <= wr_data;
                default:   focal_reg <= focal_reg;
            endcase
        end
    end

    assign cfg.focal = focal_reg;
    assign cfg.speed = speed_reg;

    // Front end and back end.
    logic accept, push, full;
    job_t job;

    assign accept = start && !full;
    assign busy   = full;

    sfp_front #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cfg        (cfg),
        .star_x     (star_x),
        .star_y     (star_y),
        .star_depth (star_depth),
        .elapsed_ms (elapsed_ms),
        .push       (push),
        .job        (job)
    );

    sfp_back #(.PQW(PQW), .LAT(LAT)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .job        (job),
        .full       (full),
        .done       (done),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .visible    (visible),
        .gray_level (gray_level),
        .next_depth (next_depth)
    );

endmodule

// File: hw/rtl/sfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks of the star projector, bound to the top level.
// ----------------------------------------------------------------------------
`include "starfield_point_project_macros.svh"

module sfp_checker #(
    parameter int SCREEN_W = 800,
    parameter int SCREEN_H = 800
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [9:0]  pixel_col,
    input logic [9:0]  pixel_row,
    input logic        visible,
    input logic [16:0] next_depth
);

    localparam logic [12:0] LIM_W = 13'(SCREEN_W);
    localparam logic [12:0] LIM_H = 13'(SCREEN_H);

    // A hidden star reports the origin pixel.
    `SFP_ASSERT_NOW(a_hidden_zero, done && !visible, pixel_col == 10'd0 && pixel_row == 10'd0, "hidden star with nonzero pixel")
    // The updated depth never exceeds 1.0.
    `SFP_ASSERT_NOW(a_depth_max, done, next_depth <= 17'd65536, "next depth above one")
    // A visible pixel lies inside the screen.
    `SFP_ASSERT_NOW(a_on_screen, done && visible, 13'(pixel_col) < LIM_W && 13'(pixel_row) < LIM_H, "visible pixel off screen")
    // With one result per clock the queue never fills.
    `SFP_ASSERT_NEXT(a_no_busy, start, !busy, "block stalled the stream")

endmodule

bind starfield_point_project sfp_checker #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
) u_sfp_checker (.*);

// File: dv/starfield_point_project_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// starfield_point_project_checker
// Predicts and checks the results of the star projector.
// ----------------------------------------------------------------------------
// Watches register writes and accepted star transactions, computes the
// expected pixel, visibility, gray level and next depth of each star, and
// compares every done strobe with the oldest expectation in order.
// ----------------------------------------------------------------------------
module starfield_point_project_checker
    import sfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [19:0]        wr_data,
    input  logic signed [15:0] star_x,
    input  logic signed [15:0] star_y,
    input  logic [16:0]        star_depth,
    input  logic [9:0]         elapsed_ms,
    input  logic               done,
    input  logic [9:0]         pixel_col,
    input  logic [9:0]         pixel_row,
    input  logic               visible,
    input  logic [7:0]         gray_level,
    input  logic [16:0]        next_depth,
    output int                 fail_count,
    output int                 pending_stars
);

    localparam int SCR_W = 800;
    localparam int SCR_H = 800;

    typedef struct packed {
        logic [9:0]  col;
        logic [9:0]  row;
        logic        vis;
        logic [7:0]  gray;
        logic [16:0] depth;
    } star_result_t;

    star_result_t expected_stars[$];
    logic [11:0]  focal;
    logic [19:0]  speed;

    // Truncated screen coordinate, or -1 when off screen.
    function automatic longint project_axis(longint pos, longint z, longint centre,
                                            longint limit);
        longint num;
        longint q;
        num = 4 * longint'(focal) * pos + centre * z;
        q = num / z;
        if (q < 0 || q >= limit)
            return -1;
        return q;
    endfunction

    function automatic star_result_t project_star(logic signed [15:0] x,
                                                  logic signed [15:0] y,
                                                  logic [16:0] z, logic [9:0] ms);
        star_result_t r;
        longint c;
        longint rw;
        longint g;
        longint stp;
        longint d;
        r = '0;
        r.gray = 8'd255;
        if (z != 0)
        begin
            c = project_axis(longint'(x), longint'(z), longint'(SCR_W / 2),
                             longint'(SCR_W));
            rw = project_axis(longint'(y), longint'(z), longint'(SCR_H / 2),
                              longint'(SCR_H));
            g = (longint'(51) << 32) / (longint'(z) * longint'(z));
            r.gray = (g > 255) ? 8'd255 : g[7:0];
            if (c >= 0 && rw >= 0)
            begin
                r.vis = 1'b1;
                r.col = c[9:0];
                r.row = rw[9:0];
            end
        end
        stp = (longint'(ms) * longint'(speed)) >>> 8;
        if (stp > 65536)
            stp = 65536;
        d = longint'(z) - stp;
        if (d <= 0)
            d += 65536;
        if (d > 65536)
            d -= 65536;
        r.depth = d[16:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending_stars = expected_stars.size();

    // Track registers, predict accepted stars and compare results.
    always @(posedge clk or negedge rst_n)
    begin
        star_result_t w;
        if (!rst_n)
        begin
            focal <= FOCAL_RESET;
            speed <= SPEED_RESET;
            expected_stars.delete();
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_stars.size() == 0)
                begin
                    // A result with no transaction outstanding.
                    report_mismatch("done", longint'(1), longint'(0));
                end
                else
                begin
                    w = expected_stars.pop_front();
                    if (pixel_col != w.col)
                        report_mismatch("pixel_col", longint'(pixel_col), longint'(w.col));
                    if (pixel_row != w.row)
                        report_mismatch("pixel_row", longint'(pixel_row), longint'(w.row));
                    if (visible != w.vis)
                        report_mismatch("visible", longint'(visible), longint'(w.vis));
                    if (gray_level != w.gray)
                        report_mismatch("gray_level", longint'(gray_level), longint'(w.gray));
                    if (next_depth != w.depth)
                        report_mismatch("next_depth", longint'(next_depth),
                                        longint'(w.depth));
                end
            end
            if (start && !busy)
                expected_stars.push_back(project_star(star_x, star_y, star_depth, elapsed_ms));
            if (wr_en)
            begin
                if (wr_index == REG_FOCAL)
                    focal <= wr_data[11:0];
                else
                    speed <= wr_data;
            end
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the star projector.
// ----------------------------------------------------------------------------
// Drives directed corner stars and then random stars under several register
// settings and idle patterns; a checker beside the block predicts each result.
// ----------------------------------------------------------------------------
module testbench;
    import sfp_pkg::*;

    localparam int LATENCY   = 14;
    localparam int MAX_CYCLE = 200000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               wr_en;
    logic               wr_index;
    logic [19:0]        wr_data;
    logic signed [15:0] star_x;
    logic signed [15:0] star_y;
    logic [16:0]        star_depth;
    logic [9:0]         elapsed_ms;
    logic               done;
    logic [9:0]         pixel_col;
    logic [9:0]         pixel_row;
    logic               visible;
    logic [7:0]         gray_level;
    logic [16:0]        next_depth;
    int                 fail_count;
    int                 pending_stars;
    int                 cycle_count;

    starfield_point_project u_top (.*);
    starfield_point_project_checker u_checker (.*);

    // Clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [19:0] val);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val;
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    // Wait for all results, then for the pipeline to empty.
    task automatic drain_pipeline();
        while (pending_stars != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Send one star transaction; stays at the falling edge after acceptance.
    task automatic send_star(logic signed [15:0] x, logic signed [15:0] y,
                             logic [16:0] z, logic [9:0] ms, int gap_pct);
        while ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        star_x = x;
        star_y = y;
        star_depth = z;
        elapsed_ms = ms;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_star(int gap_pct);
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [16:0] z;
        int k;
        k = $urandom_range(9);
        x = (k == 0) ? 16'($urandom) : 16'(int'($urandom_range(32768)) - 16384);
        y = (k == 1) ? 16'($urandom) : 16'(int'($urandom_range(32768)) - 16384);
        case ($urandom_range(5))
            0: z = 17'($urandom_range(16));
            1: z = 17'($urandom);
            2: z = 17'd65536;
            default: z = 17'($urandom_range(65536));
        endcase
        send_star(x, y, z, 10'($urandom_range(1023)), gap_pct);
    endtask

    task automatic random_phase(int n, int gap_pct);
        repeat (n) random_star(gap_pct);
        start = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_FOCAL;
        wr_data = '0;
        star_x = '0;
        star_y = '0;
        star_depth = '0;
        elapsed_ms = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Corner stars at reset settings.
        send_star(16'sd0, 16'sd0, 17'd0, 10'd0, 0);
        send_star(16'sd0, 16'sd0, 17'd0, 10'd1023, 0);
        send_star(16'sh7FFF, 16'sh8000, 17'd1, 10'd1023, 0);
        send_star(16'sh8000, 16'sh7FFF, 17'd65536, 10'd0, 0);
        send_star(16'sd16384, -16'sd16384, 17'd65536, 10'd1, 0);
        send_star(-16'sd1, 16'sd1, 17'd131071, 10'd0, 0);
        send_star(16'shFFFF, 16'shFFFF, 17'd131071, 10'd1023, 0);
        send_star(16'sd0, 16'sd0, 17'd32768, 10'd500, 0);
        send_star(16'sd100, -16'sd100, 17'd200, 10'd3, 0);
        start = 1'b0;
        drain_pipeline();

        // Extremes of both registers.
        write_reg(REG_FOCAL, 20'd4095);
        write_reg(REG_SPEED, 20'hFFFFF);
        send_star(16'sd16384, 16'sd16384, 17'd65536, 10'd1023, 0);
        send_star(16'sd1, -16'sd1, 17'd1, 10'd1, 0);
        send_star(16'sd0, 16'sd0, 17'd0, 10'd1023, 0);
        send_star(-16'sd300, 16'sd300, 17'd100000, 10'd64, 0);
        start = 1'b0;
        drain_pipeline();
        write_reg(REG_FOCAL, 20'd0);
        write_reg(REG_SPEED, 20'd0);
        send_star(16'sh7FFF, 16'sh8000, 17'd7, 10'd1023, 0);
        send_star(16'sd0, 16'sd0, 17'd0, 10'd512, 0);
        start = 1'b0;
        drain_pipeline();

        // Random phases with varied settings and idle patterns.
        write_reg(REG_FOCAL, 20'd400);
        write_reg(REG_SPEED, 20'd16777);
        random_phase(650, 9);
        drain_pipeline();
        write_reg(REG_FOCAL, 20'($urandom_range(4095)));
        write_reg(REG_SPEED, 20'($urandom));
        random_phase(650, 66);
        drain_pipeline();
        write_reg(REG_FOCAL, 20'($urandom_range(1, 800)));
        write_reg(REG_SPEED, 20'($urandom_range(65536)));
        random_phase(300, 0);
        drain_pipeline();
        write_reg(REG_FOCAL, 20'd4095);
        write_reg(REG_SPEED, 20'd1);
        random_phase(300, 0);
        drain_pipeline();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
